// ===== rtl/core/wcr_pkg.sv =====
// Shared types, codes and constants of the wavefront cell relaxation block.
package wcr_pkg;

    localparam int DIST_W      = 16;
    localparam int DIR_W       = 12;
    localparam int PHASE_W     = 13;
    localparam int OFFSET_W    = 7;
    localparam int KIND_W      = 3;
    localparam int STEP_W      = 12;
    localparam int SHIFT_W     = 4;
    localparam int TOL_W       = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [DIST_W-1:0] UNREACHED = '1;

    localparam logic [STEP_W-1:0]  RATE_STEP_RESET    = 12'd1;
    localparam logic [STEP_W-1:0]  RATE_MODULUS_RESET = 12'd64;
    localparam logic [SHIFT_W-1:0] ROT_SHIFT_RESET    = 4'd4;
    localparam logic [TOL_W-1:0]   PULSE_TOL_RESET    = 16'd16;

    typedef enum logic [KIND_W-1:0] {
        KIND_PX   = 3'd0,
        KIND_NX   = 3'd1,
        KIND_PY   = 3'd2,
        KIND_NY   = 3'd3,
        KIND_PZ   = 3'd4,
        KIND_NZ   = 3'd5,
        KIND_SELF = 3'd6,
        KIND_NONE = 3'd7
    } move_kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RATE_STEP    = 2'd0,
        REG_RATE_MODULUS = 2'd1,
        REG_ROT_SHIFT    = 2'd2,
        REG_PULSE_TOL    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [STEP_W-1:0]  rate_step;
        logic [STEP_W-1:0]  rate_modulus;
        logic [SHIFT_W-1:0] rot_shift;
        logic [TOL_W-1:0]   pulse_tol;
    } cfg_t;

    typedef struct packed {
        move_kind_t                move_kind;
        logic [OFFSET_W-1:0]       source_offset;
        logic [DIST_W-1:0]         dist2;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic [PHASE_W-1:0]        phase;
        logic [DIST_W-1:0]         pulse_dist2;
        logic                      last;
    } item_t;

    typedef struct packed {
        logic [DIST_W-1:0]         dist2;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic [PHASE_W-1:0]        phase;
        logic                      shell_active;
        logic                      newly_reached;
    } result_t;

endpackage

// ===== rtl/core/wavefront_cell_relax_top.sv =====
// Top level of the wavefront cell relaxation block: input and result registers.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | input     | in_valid / in_ready   | move_kind .. last_offer, one offer word
//  out     | output    | out_valid / out_ready | out_dist2 .. newly_reached, one cell word
//  cfg     | input     | cfg_write_en          | cfg_index, cfg_data
//
// One word is accepted per cycle unless a last word is held in the input register; a result
// passes from the input register into the result register around the relax datapath.
// Reset loads the register defaults and an unreached running state.
// Only a last word stalls: it waits in the input register while the result register
// holds a word that has not been taken; other words keep flowing.
module wavefront_cell_relax_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [wcr_pkg::KIND_W-1:0]          move_kind,
    input  logic [wcr_pkg::OFFSET_W-1:0]        source_offset,
    input  logic [wcr_pkg::DIST_W-1:0]          in_dist2,
    input  logic signed [wcr_pkg::DIR_W-1:0]    in_dir_x,
    input  logic signed [wcr_pkg::DIR_W-1:0]    in_dir_y,
    input  logic [wcr_pkg::PHASE_W-1:0]         in_phase,
    input  logic [wcr_pkg::DIST_W-1:0]          pulse_dist2,
    input  logic                                last_offer,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [wcr_pkg::DIST_W-1:0]          out_dist2,
    output logic signed [wcr_pkg::DIR_W-1:0]    out_dir_x,
    output logic signed [wcr_pkg::DIR_W-1:0]    out_dir_y,
    output logic [wcr_pkg::PHASE_W-1:0]         out_phase,
    output logic                                shell_active,
    output logic                                newly_reached,
    input  logic                                cfg_write_en,
    input  logic [wcr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wcr_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import wcr_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t relax_result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    advance;

    wcr_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    wcr_relax u_relax (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (item_reg),
        .advance (advance),
        .result  (relax_result)
    );

    // A last word may only move on when the result register is free or being emptied.
    assign advance  = item_valid_reg && (!item_reg.last || !out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.move_kind     <= move_kind_t'(move_kind);
            item_reg.source_offset <= source_offset;
            item_reg.dist2         <= in_dist2;
            item_reg.dir_x         <= in_dir_x;
            item_reg.dir_y         <= in_dir_y;
            item_reg.phase         <= in_phase;
            item_reg.pulse_dist2   <= pulse_dist2;
            item_reg.last          <= last_offer;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && item_reg.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_reg.last)
        begin
            result_reg <= relax_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_dist2     = result_reg.dist2;
    assign out_dir_x     = result_reg.dir_x;
    assign out_dir_y     = result_reg.dir_y;
    assign out_phase     = result_reg.phase;
    assign shell_active  = result_reg.shell_active;
    assign newly_reached = result_reg.newly_reached;

`ifndef SYNTHESIS
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && item_reg.last))
        else $error("result word appeared without a last word leaving the input register");

    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid_reg |-> in_ready)
        else $error("input refused while the input register is empty");

    a_active_is_reached: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result_reg.shell_active || result_reg.newly_reached))
            |-> (result_reg.dist2 != UNREACHED))
        else $error("active or newly reached flag on an unreached cell");

    a_held_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(result_reg))
        else $error("waiting result word changed before it was taken");
`endif

endmodule

// ===== rtl/core/wcr_cfg.sv =====
// Configuration register file of the wavefront cell relaxation block.
module wcr_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [wcr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wcr_pkg::CFG_DATA_W-1:0]      cfg_data,
    output wcr_pkg::cfg_t                       cfg
);
    import wcr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_RATE_STEP:    cfg_next.rate_step    = cfg_data[STEP_W-1:0];
                REG_RATE_MODULUS: cfg_next.rate_modulus = cfg_data[STEP_W-1:0];
                REG_ROT_SHIFT:    cfg_next.rot_shift    = cfg_data[SHIFT_W-1:0];
                REG_PULSE_TOL:    cfg_next.pulse_tol    = cfg_data[TOL_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate_step    <= RATE_STEP_RESET;
            cfg_reg.rate_modulus <= RATE_MODULUS_RESET;
            cfg_reg.rot_shift    <= ROT_SHIFT_RESET;
            cfg_reg.pulse_tol    <= PULSE_TOL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/wcr_relax.sv =====
// Running best state of one cell and the single-pass relaxation datapath.
module wcr_relax (
    input  logic              clk,
    input  logic              rst_n,
    input  wcr_pkg::cfg_t     cfg,
    input  wcr_pkg::item_t    item,
    input  logic              advance,
    output wcr_pkg::result_t  result
);
    import wcr_pkg::*;

    logic [DIST_W-1:0]       best_dist2_reg, best_dist2_next;
    logic signed [DIR_W-1:0] best_dir_x_reg, best_dir_x_next;
    logic signed [DIR_W-1:0] best_dir_y_reg, best_dir_y_next;
    logic [PHASE_W-1:0]      best_phase_reg, best_phase_next;
    logic                    was_unreached_reg, was_unreached_next;

    logic [DIST_W:0]         cand;
    logic                    offer;
    logic                    take;
    logic                    z_move;
    logic [PHASE_W:0]        acc;
    logic [PHASE_W:0]        modulus_ext;
    logic                    rotate;
    logic [PHASE_W:0]        acc_adj;
    logic signed [DIR_W-1:0] rx;
    logic signed [DIR_W-1:0] ry;
    logic signed [DIR_W-1:0] rot_x;
    logic signed [DIR_W-1:0] rot_y;
    logic [DIST_W-1:0]       gap;
    logic                    reached;

    always_comb
    begin
        // Proposal is source distance plus 2*offset+1, kept at 17 bits.
        cand = {1'b0, item.dist2} + {{(DIST_W-OFFSET_W){1'b0}}, item.source_offset, 1'b1};

        case (item.move_kind) inside
            KIND_PX, KIND_NX, KIND_PY, KIND_NY, KIND_PZ, KIND_NZ:
                offer = (item.dist2 != UNREACHED);
            default:
                offer = 1'b0;
        endcase
        take = offer && (cand < {1'b0, best_dist2_reg});

        z_move      = (item.move_kind == KIND_PZ) || (item.move_kind == KIND_NZ);
        acc         = {1'b0, item.phase} + {{(PHASE_W+1-STEP_W){1'b0}}, cfg.rate_step};
        modulus_ext = {{(PHASE_W+1-STEP_W){1'b0}}, cfg.rate_modulus};
        rotate      = (acc >= modulus_ext);
        acc_adj     = rotate ? (acc - modulus_ext) : acc;

        rx = $signed(item.dir_y) >>> cfg.rot_shift;
        ry = $signed(item.dir_x) >>> cfg.rot_shift;
        if (!rotate)
        begin
            rot_x = item.dir_x;
            rot_y = item.dir_y;
        end
        else if (item.move_kind == KIND_PZ)
        begin
            rot_x = item.dir_x - rx;
            rot_y = item.dir_y + ry;
        end
        else
        begin
            rot_x = item.dir_x + rx;
            rot_y = item.dir_y - ry;
        end

        best_dist2_next    = best_dist2_reg;
        best_dir_x_next    = best_dir_x_reg;
        best_dir_y_next    = best_dir_y_reg;
        best_phase_next    = best_phase_reg;
        was_unreached_next = was_unreached_reg;

        if (item.move_kind == KIND_SELF)
        begin
            best_dist2_next    = item.dist2;
            best_dir_x_next    = item.dir_x;
            best_dir_y_next    = item.dir_y;
            best_phase_next    = item.phase;
            was_unreached_next = (item.dist2 == UNREACHED);
        end
        else if (take)
        begin
            best_dist2_next = cand[DIST_W-1:0];
            if (z_move)
            begin
                best_dir_x_next = rot_x;
                best_dir_y_next = rot_y;
                best_phase_next = acc_adj[PHASE_W-1:0];
            end
            else
            begin
                best_dir_x_next = item.dir_x;
                best_dir_y_next = item.dir_y;
                best_phase_next = item.phase;
            end
        end

        reached = (best_dist2_next != UNREACHED);
        gap     = (best_dist2_next > item.pulse_dist2) ? (best_dist2_next - item.pulse_dist2)
                                                       : (item.pulse_dist2 - best_dist2_next);

        result.dist2         = best_dist2_next;
        result.dir_x         = best_dir_x_next;
        result.dir_y         = best_dir_y_next;
        result.phase         = best_phase_next;
        result.shell_active  = reached && (gap <= cfg.pulse_tol);
        result.newly_reached = was_unreached_next && reached;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_dist2_reg    <= UNREACHED;
            best_dir_x_reg    <= '0;
            best_dir_y_reg    <= '0;
            best_phase_reg    <= '0;
            was_unreached_reg <= 1'b1;
        end
        else if (advance)
        begin
            best_dist2_reg    <= best_dist2_next;
            best_dir_x_reg    <= best_dir_x_next;
            best_dir_y_reg    <= best_dir_y_next;
            best_phase_reg    <= best_phase_next;
            was_unreached_reg <= was_unreached_next;
        end
    end

endmodule
